### rtl/lsfe_pkg.sv
// ----------------------------------------------------------------------------
// lsfe_pkg
// Shared types and codes for the hidden frame extractor.
// ----------------------------------------------------------------------------
package lsfe_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [1:0] KIND_EXT = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MAGIC  = 2'd1;
  localparam logic [1:0] ST_EXTLEN = 2'd2;

  localparam logic [1:0] CFG_HEADER_SKIP  = 2'd0;
  localparam logic [1:0] CFG_MAGIC_LENGTH = 2'd1;
  localparam logic [1:0] CFG_MAGIC_VALUE  = 2'd2;
  localparam logic [1:0] CFG_SUFFIX_LIMIT = 2'd3;

  typedef struct packed {
    logic [9:0]  header_skip;
    logic [3:0]  magic_length;
    logic [63:0] magic_value;
    logic [7:0]  suffix_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [1:0]  status;
    logic        last;
    logic [31:0] declared_size;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

### rtl/lsfe_parser.sv
// ----------------------------------------------------------------------------
// lsfe_parser
// Front end: skips the header, gathers bits and classifies each hidden field.
// ----------------------------------------------------------------------------
module lsfe_parser
  import lsfe_pkg::*;
#(
  parameter int EXT_BYTES = 4,
  parameter int MAX_MAGIC = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       take,
  input  logic [7:0] image_byte,
  input  logic       frame_start,
  output push_t      push
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_MAGIC   = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_EXT     = 3'd3;
  localparam logic [2:0] PH_SIZE    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [9:0]  hcount_r, hcount_nxt;
  logic [4:0]  bcount_r, bcount_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [3:0]  fcount_r, fcount_nxt;
  logic        magic_ok_r, magic_ok_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [31:0] size_r, size_nxt;

  logic [3:0] eff_len;
  assign eff_len = (cfg.magic_length > 4'(MAX_MAGIC)) ? 4'(MAX_MAGIC) : cfg.magic_length;

  always_comb begin
    logic [2:0]  ph;
    logic [31:0] sh2;
    logic        complete;
    logic [3:0]  fc1;
    logic [2:0]  bsel;
    logic [7:0]  expect_byte;
    logic [31:0] rem1;
    result_t     blank;

    blank = '0;
    push = '0;
    push.r0 = blank;
    push.r1 = blank;
    phase_nxt    = frame_start ? PH_HEADER : phase_r;
    hcount_nxt   = frame_start ? '0 : hcount_r;
    bcount_nxt   = frame_start ? '0 : bcount_r;
    shift_nxt    = frame_start ? '0 : shift_r;
    fcount_nxt   = frame_start ? '0 : fcount_r;
    magic_ok_nxt = frame_start ? 1'b1 : magic_ok_r;
    remain_nxt   = frame_start ? '0 : remain_r;
    size_nxt     = frame_start ? '0 : size_r;
    ph = phase_nxt;
    sh2 = '0;
    complete = 1'b0;
    fc1 = '0;
    bsel = '0;
    expect_byte = '0;
    rem1 = '0;

    if (ph == PH_HEADER) begin
      if (hcount_nxt < cfg.header_skip) begin
        hcount_nxt = hcount_nxt + 10'd1;
        ph = PH_DONE + 3'd1;
      end else begin
        ph = (eff_len == 4'd0) ? PH_EXTLEN : PH_MAGIC;
        fcount_nxt = '0;
        bcount_nxt = '0;
        shift_nxt = '0;
        phase_nxt = ph;
      end
    end

    if (ph < PH_DONE) begin
      sh2 = {shift_nxt[30:0], image_byte[0]};
      complete = (ph == PH_EXTLEN || ph == PH_SIZE) ? (bcount_nxt == 5'd31)
                                                    : (bcount_nxt == 5'd7);
      if (!complete) begin
        bcount_nxt = bcount_nxt + 5'd1;
        shift_nxt = sh2;
      end else begin
        bcount_nxt = '0;
        shift_nxt = '0;
        fc1 = fcount_nxt + 4'd1;
        case (ph)
          PH_MAGIC: begin
            if (fcount_nxt < eff_len) begin
              bsel = 3'(eff_len - 4'd1 - fcount_nxt);
              expect_byte = cfg.magic_value[{bsel, 3'b000} +: 8];
              if (expect_byte != sh2[7:0]) magic_ok_nxt = 1'b0;
            end else begin
              magic_ok_nxt = 1'b0;
            end
            fcount_nxt = fc1;
            if (fc1 >= eff_len) begin
              fcount_nxt = '0;
              if (!magic_ok_nxt) begin
                push.count = 2'd1;
                push.r0.kind = KIND_END;
                push.r0.status = ST_MAGIC;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_EXTLEN;
              end
            end
          end
          PH_EXTLEN: begin
            if (!sh2[31] && (sh2 > {24'd0, cfg.suffix_limit})) begin
              push.count = 2'd1;
              push.r0.kind = KIND_END;
              push.r0.status = ST_EXTLEN;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_EXT;
              fcount_nxt = '0;
            end
          end
          PH_EXT: begin
            push.count = 2'd1;
            push.r0.kind = KIND_EXT;
            push.r0.value = sh2[7:0];
            fcount_nxt = fc1;
            if (fc1 >= 4'(EXT_BYTES)) begin
              fcount_nxt = '0;
              phase_nxt = PH_SIZE;
            end
          end
          PH_SIZE: begin
            size_nxt = sh2;
            remain_nxt = sh2[31] ? '0 : sh2;
            if (remain_nxt == 32'd0) begin
              push.count = 2'd1;
              push.r0.kind = KIND_END;
              push.r0.status = ST_OK;
              push.r0.declared_size = sh2;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
          default: begin
            rem1 = remain_nxt - 32'd1;
            remain_nxt = rem1;
            push.count = 2'd1;
            push.r0.kind = KIND_PAY;
            push.r0.value = sh2[7:0];
            push.r0.last = (rem1 == 32'd0);
            if (rem1 == 32'd0) begin
              push.count = 2'd2;
              push.r1.kind = KIND_END;
              push.r1.status = ST_OK;
              push.r1.declared_size = size_nxt;
              phase_nxt = PH_DONE;
            end
          end
        endcase
      end
    end

    if (!take) push.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hcount_r   <= '0;
      bcount_r   <= '0;
      shift_r    <= '0;
      fcount_r   <= '0;
      magic_ok_r <= 1'b1;
      remain_r   <= '0;
      size_r     <= '0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      hcount_r   <= hcount_nxt;
      bcount_r   <= bcount_nxt;
      shift_r    <= shift_nxt;
      fcount_r   <= fcount_nxt;
      magic_ok_r <= magic_ok_nxt;
      remain_r   <= remain_nxt;
      size_r     <= size_nxt;
    end
  end

endmodule

### rtl/lsfe_queue.sv
// ----------------------------------------------------------------------------
// lsfe_queue
// Back end: short result queue that takes up to two results per beat and
// drives the output channel from its head entry.
// ----------------------------------------------------------------------------
module lsfe_queue
  import lsfe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  result_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign head      = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r + QPTR_W'(push.count);
    rptr_nxt  = rptr_r + QPTR_W'(pop);
    count_nxt = count_r + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wptr_r] <= push.r0;
    if (push.count == 2'd2) mem_r[wptr_r + QPTR_W'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/lsb_stego_frame_extractor_unit.sv
// a result is written into the result queue on its beat and reaches the output once it is the head entry
// throughput: one image byte per cycle while in_ready is high; the parser updates its counters per beat
// in_ready drops only while the four-entry result queue holds more than two results
// reset: synchronous, active low; clears parser state and queue, loads register defaults
// ----------------------------------------------------------------------------
// lsb_stego_frame_extractor_unit
// Pulls hidden extension and payload bytes out of the low bits of image bytes.
// ----------------------------------------------------------------------------
module lsb_stego_frame_extractor_unit
  import lsfe_pkg::*;
#(
  parameter int EXT_BYTES = 4,
  parameter int MAX_MAGIC = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_image_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_value,
  output logic [1:0]  out_status,
  output logic        out_last,
  output logic [31:0] out_declared_size
);

  cfg_t    cfg_r;
  push_t   push;
  result_t head;
  logic    room;
  logic    take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_skip  <= 10'd54;
      cfg_r.magic_length <= 4'd2;
      cfg_r.magic_value  <= 64'd9002;
      cfg_r.suffix_limit <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_SKIP:  cfg_r.header_skip  <= cfg_data[9:0];
        CFG_MAGIC_LENGTH: cfg_r.magic_length <= cfg_data[3:0];
        CFG_MAGIC_VALUE:  cfg_r.magic_value  <= cfg_data;
        CFG_SUFFIX_LIMIT: cfg_r.suffix_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = room;
  assign take     = in_valid && in_ready;

  lsfe_parser #(
    .EXT_BYTES(EXT_BYTES),
    .MAX_MAGIC(MAX_MAGIC)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .take       (take),
    .image_byte (in_image_byte),
    .frame_start(in_frame_start),
    .push       (push)
  );

  lsfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_kind          = head.kind;
  assign out_value         = head.value;
  assign out_status        = head.status;
  assign out_last          = head.last;
  assign out_declared_size = head.declared_size;

`ifndef SYNTHESIS
  a_stall_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result queue");

  a_data_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_END |-> out_declared_size == 32'd0 && out_status == ST_OK)
    else $error("data beat carries end record fields");

  a_error_no_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_kind == KIND_END && out_declared_size == 32'd0)
    else $error("error status outside an end record");

  a_no_push_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) |-> push.count == 2'd0)
    else $error("result pushed without an input beat");
`endif

endmodule
